/* sv/vcr_pkg.sv */
`timescale 1ns / 1ps
package vcr_pkg;

  localparam int COLS_DEFAULT   = 40;
  localparam int LINES_PER_CELL = 8;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [1:0] CFG_RENDER_MODE = 2'd0;
  localparam logic [1:0] CFG_CONCEAL     = 2'd1;

  localparam logic [1:0] RM_HYBRID     = 2'd0;
  localparam logic [1:0] RM_DITHER_ALL = 2'd1;

  localparam logic [1:0] CS_G1 = 2'd1;

  localparam logic [6:0] MOSAIC_TOP_BAR = 7'h60;

  typedef logic [7:0][5:0] vcr_glyph_t;

  typedef struct packed {
    vcr_glyph_t  glyph;
    logic [5:0]  col;
    logic [4:0]  row;
    logic        inv;
    logic        wide;
    logic        dheight;
    logic        right_fits;
  } vcr_job_t;

  function automatic logic [5:0] dither_row(input logic [2:0] ink, input logic [2:0] line);
    logic [5:0] r;
    case (ink)
      3'd0: r = 6'h00;
      3'd1: begin
        case (line)
          3'd0, 3'd3, 3'd6: r = 6'h24;
          3'd1, 3'd4, 3'd7: r = 6'h09;
          default: r = 6'h12;
        endcase
      end
      3'd2: r = line[0] ? 6'h15 : 6'h2A;
      3'd3: begin
        case (line[1:0])
          2'd1: r = 6'h1B;
          2'd3: r = 6'h36;
          default: r = 6'h3F;
        endcase
      end
      3'd4: begin
        case (line[1:0])
          2'd0: r = 6'h21;
          2'd1: r = 6'h12;
          2'd2: r = 6'h04;
          default: r = 6'h08;
        endcase
      end
      3'd5: r = line[0] ? 6'h12 : 6'h2A;
      3'd6: begin
        case (line[1:0])
          2'd1: r = 6'h2A;
          2'd3: r = 6'h15;
          default: r = 6'h3F;
        endcase
      end
      default: r = 6'h3F;
    endcase
    return r;
  endfunction

  function automatic vcr_glyph_t mosaic_glyph(input logic [6:0] code, input logic sep);
    vcr_glyph_t g;
    logic [5:0] pat;
    logic [5:0] lm;
    logic [5:0] rm;
    logic [5:0] top;
    logic [5:0] mid;
    logic [5:0] bot;
    pat = {code[6], code[4:0]};
    lm  = sep ? 6'h30 : 6'h38;
    rm  = sep ? 6'h03 : 6'h07;
    top = (pat[0] ? lm : 6'h00) | (pat[1] ? rm : 6'h00);
    mid = (pat[2] ? lm : 6'h00) | (pat[3] ? rm : 6'h00);
    bot = (pat[4] ? lm : 6'h00) | (pat[5] ? rm : 6'h00);
    if (code == MOSAIC_TOP_BAR) begin
      g = '0;
      g[0] = 6'h3F;
    end else if (sep) begin
      g = {6'h00, bot, 6'h00, mid, mid, 6'h00, top, top};
    end else begin
      g = {bot, bot, mid, mid, mid, top, top, top};
    end
    return g;
  endfunction

  function automatic logic [5:0] widen3(input logic [2:0] v);
    return {v[2], v[2], v[1], v[1], v[0], v[0]};
  endfunction

endpackage

/* sv/vcr_front.sv */
`timescale 1ns / 1ps
module vcr_front import vcr_pkg::*; #(
  parameter int COLS = COLS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [1:0]      cfg_data,
  input  logic [6:0]      char_code,
  input  logic [1:0]      charset,
  input  logic [4:0]      attr_flags,
  input  logic [1:0]      size_mode,
  input  logic [2:0]      ink_color,
  input  logic [5:0]      column,
  input  logic [4:0]      text_row,
  input  logic [47:0]     font_glyph,
  input  logic            blink_off,
  output vcr_job_t        job
);

  logic [1:0] render_mode;
  logic       conceal_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      render_mode    <= RM_HYBRID;
      conceal_enable <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_RENDER_MODE) render_mode <= cfg_data;
      else if (cfg_index == CFG_CONCEAL) conceal_enable <= cfg_data[0];
    end
  end

  logic       concealed;
  logic       flash_blank;
  logic       dith;
  vcr_glyph_t g;

  assign concealed   = attr_flags[0] & conceal_enable;
  assign flash_blank = attr_flags[2] & blink_off;
  assign dith = (render_mode == RM_DITHER_ALL) ||
                ((render_mode == RM_HYBRID) && (charset == CS_G1));

  always_comb begin
    if (concealed) g = '0;
    else if (charset == CS_G1) g = mosaic_glyph(char_code, attr_flags[3]);
    else g = vcr_glyph_t'(font_glyph);
    if (attr_flags[4]) g[7] = 6'h3F;
    if (dith) begin
      for (int i = 0; i < LINES_PER_CELL; i++) begin
        g[i] = g[i] & dither_row(ink_color, 3'(i));
      end
    end
    // A flashing cell in its off phase is a plain blank cell.
    if (flash_blank) g = '0;
  end

  always_comb begin
    job.glyph      = g;
    job.col        = column;
    job.row        = text_row;
    job.inv        = attr_flags[1];
    job.wide       = size_mode[1] & ~flash_blank;
    job.dheight    = size_mode[0] & ~flash_blank;
    job.right_fits = 7'(column) < 7'(COLS - 1);
  end

endmodule

/* sv/vcr_queue.sv */
`timescale 1ns / 1ps
module vcr_queue import vcr_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  vcr_job_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output vcr_job_t head
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  vcr_job_t         entries [DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

/* sv/vcr_back.sv */
`timescale 1ns / 1ps
module vcr_back import vcr_pkg::*; #(
  parameter int COLS = COLS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  vcr_job_t    head,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  output logic        m_tlast
);

  logic        half;
  logic [2:0]  line;
  logic        side;

  logic        advance;
  logic        step_right;
  logic        more_upper;
  logic        last;
  logic [2:0]  gidx;
  logic [4:0]  row_sel;
  logic [7:0]  scan;
  logic [5:0]  gline;
  logic [5:0]  pix;
  logic [15:0] addr_full;

  logic [12:0] fb_address;
  logic [7:0]  fb_byte;

  assign advance    = head_valid && (!m_tvalid || m_tready);
  assign step_right = head.wide && !side && head.right_fits;
  assign more_upper = head.dheight && !half && (head.row != 5'd0);
  assign last       = !step_right && (line == 3'd7) && !more_upper;
  assign pop        = advance && last;

  // Double height: the lower glyph half goes to this row, each line twice.
  assign gidx    = head.dheight ? {~half, line[2:1]} : line;
  assign row_sel = half ? head.row - 5'd1 : head.row;
  assign scan    = 8'(row_sel) * 8'(LINES_PER_CELL) + 8'(line);
  assign gline   = head.glyph[gidx];
  assign pix     = !head.wide ? gline : (side ? widen3(gline[2:0]) : widen3(gline[5:3]));
  assign addr_full = 16'(scan) * 16'(COLS) + 16'(head.col) + 16'(side);

  always_ff @(posedge clk) begin
    if (rst) begin
      half     <= 1'b0;
      line     <= 3'd0;
      side     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        m_tvalid <= 1'b1;
        if (step_right) begin
          side <= 1'b1;
        end else begin
          side <= 1'b0;
          line <= line + 3'd1;
          if (line == 3'd7) half <= more_upper;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fb_address <= addr_full[12:0];
      fb_byte    <= {head.inv, 1'b1, pix};
      m_tlast    <= last;
    end
  end

  assign m_tdata = {3'b000, fb_byte, fb_address};

  a_upper_half: assert property (@(posedge clk) disable iff (rst)
    head_valid && half |-> head.dheight && (head.row != 5'd0))
    else $error("upper half walked for a cell without a row above");

  a_right_side: assert property (@(posedge clk) disable iff (rst)
    head_valid && side |-> head.wide && head.right_fits)
    else $error("right byte produced for a narrow or clipped cell");

  a_counters_rearm: assert property (@(posedge clk) disable iff (rst)
    pop |=> !half && (line == 3'd0) && !side)
    else $error("counters not rearmed after the final write of a cell");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid && (m_tlast == $past(last)))
    else $error("final write flag lost");

endmodule

/* sv/videotex_cell_rasterizer_top.sv */
`timescale 1ns / 1ps
// Renders one videotex character cell per input request into framebuffer byte writes
// (address and pixel byte), one write per clock from the output register while the sink
// is ready and a cell is queued. A cell makes 8 writes for normal size or a blanked
// flash cell, 8 or 16 for double width (16 unless the cell sits at or past the last
// column), 16 for double height (8 on row 0), and up to 32 for double size. The front
// end builds the glyph in the cycle of the request and accepts a new cell every cycle
// while its four-entry queue has room, so the write sequencer sets the sustained rate.
module videotex_cell_rasterizer_top import vcr_pkg::*; #(
  parameter int COLS        = COLS_DEFAULT,
  parameter int QUEUE_DEPTH = vcr_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata from bit 0: char_code(7), attr_flags(5), size_mode(2), ink_color(3),
  // column(6), char_row(5), font_glyph(48), blink_off(1), zero pad(3)
  input  logic [79:0] s_tdata,
  // s_tuser: charset(2)
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata from bit 0: fb_address(13), fb_byte(8), zero pad(3)
  output logic [23:0] m_tdata,
  output logic        m_tlast
);

  vcr_job_t front_job;
  vcr_job_t head;
  logic     full;
  logic     head_valid;
  logic     pop;

  assign cfg_ready = 1'b1;
  assign s_tready  = !full;

  vcr_front #(.COLS(COLS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .char_code  (s_tdata[6:0]),
    .charset    (s_tuser),
    .attr_flags (s_tdata[11:7]),
    .size_mode  (s_tdata[13:12]),
    .ink_color  (s_tdata[16:14]),
    .column     (s_tdata[22:17]),
    .text_row   (s_tdata[27:23]),
    .font_glyph (s_tdata[75:28]),
    .blink_off  (s_tdata[76]),
    .job        (front_job)
  );

  vcr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (s_tvalid && s_tready),
    .push_data  (front_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  vcr_back #(.COLS(COLS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import vcr_pkg::*;

  localparam int COLS_TB        = COLS_DEFAULT;
  localparam int DRAIN_CYCLES   = 16;
  localparam int TAIL_CYCLES    = 48;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_PHASES  = 5;
  localparam int PHASE_CELLS    = 41;

  localparam logic [1:0] CS_G0    = 2'd0;
  localparam logic [1:0] CS_G2    = 2'd2;
  localparam logic [1:0] CS_SPARE = 2'd3;

  localparam logic [1:0] RM_RAW   = 2'd2;
  localparam logic [1:0] RM_SPARE = 2'd3;

  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;

  localparam logic [1:0] SZ_NORMAL  = 2'd0;
  localparam logic [1:0] SZ_DHEIGHT = 2'd1;
  localparam logic [1:0] SZ_DWIDTH  = 2'd2;
  localparam logic [1:0] SZ_DSIZE   = 2'd3;

  localparam logic [4:0] F_NONE      = 5'h00;
  localparam logic [4:0] F_CONCEAL   = 5'h01;
  localparam logic [4:0] F_INVERT    = 5'h02;
  localparam logic [4:0] F_FLASH     = 5'h04;
  localparam logic [4:0] F_SEPARATED = 5'h08;
  localparam logic [4:0] F_UNDERLINE = 5'h10;

  localparam logic [47:0] FONT_ONES = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] FONT_ZERO = 48'h0;
  localparam logic [47:0] FONT_ALT  = 48'hAAAA_AAAA_AAAA;
  localparam logic [47:0] FONT_MIX  = 48'h5A3C_C35A_0F1E;

  typedef logic [7:0][5:0] glyph_lines_t;

  typedef struct packed {
    logic [6:0]  code;
    logic [1:0]  cs;
    logic [4:0]  flags;
    logic [1:0]  size;
    logic [2:0]  ink;
    logic [5:0]  col;
    logic [4:0]  row;
    logic [47:0] font;
    logic        blink;
  } cell_t;

  typedef struct packed {
    logic [12:0] addr;
    logic [7:0]  pix;
    logic        last;
  } fb_write_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [1:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tlast;

  logic [1:0]  render_mode_cfg = RM_HYBRID;
  logic        conceal_cfg = 1'b0;
  logic        no_idle = 1'b0;
  int          err_count = 0;
  int          quiet_cycles;
  fb_write_t   pending_writes[$];
  fb_write_t   staged_writes[$];
  fb_write_t   expected_write;

  videotex_cell_rasterizer_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    m_tready <= no_idle || ($urandom_range(0, 99) >= 36);
  end

  function automatic glyph_lines_t ink_pattern(input logic [2:0] ink);
    glyph_lines_t p;
    case (ink)
      3'd0: p = '0;
      3'd1: p = {6'h09, 6'h24, 6'h12, 6'h09, 6'h24, 6'h12, 6'h09, 6'h24};
      3'd2: p = {6'h15, 6'h2A, 6'h15, 6'h2A, 6'h15, 6'h2A, 6'h15, 6'h2A};
      3'd3: p = {6'h36, 6'h3F, 6'h1B, 6'h3F, 6'h36, 6'h3F, 6'h1B, 6'h3F};
      3'd4: p = {6'h08, 6'h04, 6'h12, 6'h21, 6'h08, 6'h04, 6'h12, 6'h21};
      3'd5: p = {6'h12, 6'h2A, 6'h12, 6'h2A, 6'h12, 6'h2A, 6'h12, 6'h2A};
      3'd6: p = {6'h15, 6'h3F, 6'h2A, 6'h3F, 6'h15, 6'h3F, 6'h2A, 6'h3F};
      default: p = {8{6'h3F}};
    endcase
    return p;
  endfunction

  function automatic glyph_lines_t mosaic_lines(input logic [6:0] code, input logic sep);
    glyph_lines_t g;
    logic [5:0] blocks;
    logic [5:0] lmask;
    logic [5:0] rmask;
    logic [5:0] top;
    logic [5:0] mid;
    logic [5:0] bot;
    g = '0;
    if (code == MOSAIC_TOP_BAR) begin
      g[0] = 6'h3F;
      return g;
    end
    blocks = {code[6], code[4:0]};
    lmask = sep ? 6'h30 : 6'h38;
    rmask = sep ? 6'h03 : 6'h07;
    top = (blocks[0] ? lmask : 6'h00) | (blocks[1] ? rmask : 6'h00);
    mid = (blocks[2] ? lmask : 6'h00) | (blocks[3] ? rmask : 6'h00);
    bot = (blocks[4] ? lmask : 6'h00) | (blocks[5] ? rmask : 6'h00);
    g[0] = top;
    g[1] = top;
    g[3] = mid;
    g[4] = mid;
    g[6] = bot;
    if (!sep) begin
      g[2] = top;
      g[5] = mid;
      g[7] = bot;
    end
    return g;
  endfunction

  function automatic logic [5:0] double_pixels(input logic [2:0] v);
    logic [5:0] w;
    for (int b = 0; b < 3; b++) w[2*b +: 2] = {2{v[b]}};
    return w;
  endfunction

  function automatic void stage_write(input int scanline, input int col, input logic [7:0] pix);
    fb_write_t w;
    int a;
    a = scanline * COLS_TB + col;
    w.addr = a[12:0];
    w.pix = pix;
    w.last = 1'b0;
    staged_writes.push_back(w);
  endfunction

  function automatic void stage_line(input int scanline, input int col, input logic [5:0] line,
                                     input logic wide, input logic right_fits,
                                     input logic [7:0] inv);
    if (wide) begin
      stage_write(scanline, col, {2'b00, double_pixels(line[5:3])} | inv);
      if (right_fits) stage_write(scanline, col + 1, {2'b00, double_pixels(line[2:0])} | inv);
    end else begin
      stage_write(scanline, col, {2'b00, line} | inv);
    end
  endfunction

  function automatic void rasterize_cell(input cell_t c);
    glyph_lines_t g;
    logic [7:0] inv;
    logic dith;
    logic right_fits;
    logic wide;
    int base;
    int col;
    fb_write_t w;
    staged_writes.delete();
    inv = ((c.flags & F_INVERT) != 0) ? 8'hC0 : 8'h40;
    base = int'(c.row) * LINES_PER_CELL;
    col = int'(c.col);
    right_fits = col < COLS_TB - 1;
    if (((c.flags & F_FLASH) != 0) && c.blink) begin
      for (int i = 0; i < 8; i++) stage_write(base + i, col, inv);
    end else begin
      if (((c.flags & F_CONCEAL) != 0) && conceal_cfg) begin
        g = '0;
      end else if (c.cs == CS_G1) begin
        g = mosaic_lines(c.code, (c.flags & F_SEPARATED) != 0);
      end else begin
        g = c.font;
      end
      if ((c.flags & F_UNDERLINE) != 0) g[7] = 6'h3F;
      dith = (render_mode_cfg == RM_DITHER_ALL) ||
             (render_mode_cfg == RM_HYBRID && c.cs == CS_G1);
      if (dith) g = g & ink_pattern(c.ink);
      if (c.size == SZ_DHEIGHT || c.size == SZ_DSIZE) begin
        wide = c.size == SZ_DSIZE;
        for (int i = 0; i < 4; i++) begin
          stage_line(base + 2*i, col, g[i+4], wide, right_fits, inv);
          stage_line(base + 2*i + 1, col, g[i+4], wide, right_fits, inv);
        end
        if (c.row != 0) begin
          for (int i = 0; i < 4; i++) begin
            stage_line(base - LINES_PER_CELL + 2*i, col, g[i], wide, right_fits, inv);
            stage_line(base - LINES_PER_CELL + 2*i + 1, col, g[i], wide, right_fits, inv);
          end
        end
      end else begin
        for (int i = 0; i < 8; i++) begin
          stage_line(base + i, col, g[i], c.size == SZ_DWIDTH, right_fits, inv);
        end
      end
    end
    w = staged_writes.pop_back();
    w.last = 1'b1;
    staged_writes.push_back(w);
    while (staged_writes.size() != 0) pending_writes.push_back(staged_writes.pop_front());
  endfunction

  function automatic cell_t make_cell(input logic [6:0] code, input logic [1:0] cs,
                                      input logic [4:0] flags, input logic [1:0] size,
                                      input logic [2:0] ink, input logic [5:0] col,
                                      input logic [4:0] row, input logic [47:0] font,
                                      input logic blink);
    cell_t c;
    c.code = code;
    c.cs = cs;
    c.flags = flags;
    c.size = size;
    c.ink = ink;
    c.col = col;
    c.row = row;
    c.font = font;
    c.blink = blink;
    return c;
  endfunction

  function automatic cell_t random_cell();
    cell_t c;
    logic [31:0] r_hi;
    logic [31:0] r_lo;
    r_hi = $urandom;
    r_lo = $urandom;
    c.code = 7'($urandom_range(0, 127));
    if ($urandom_range(0, 19) == 0) c.code = MOSAIC_TOP_BAR;
    c.cs = ($urandom_range(0, 9) == 0) ? CS_SPARE : 2'($urandom_range(0, 2));
    c.flags = 5'($urandom_range(0, 31));
    c.size = 2'($urandom_range(0, 3));
    c.ink = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 9))
      7: c.col = 6'($urandom_range(COLS_TB - 2, COLS_TB - 1));
      8: c.col = '0;
      9: c.col = 6'($urandom_range(COLS_TB, 63));
      default: c.col = 6'($urandom_range(0, COLS_TB - 1));
    endcase
    case ($urandom_range(0, 9))
      8: c.row = '0;
      9: c.row = 5'($urandom_range(25, 31));
      default: c.row = 5'($urandom_range(0, 24));
    endcase
    c.font = {r_hi[15:0], r_lo};
    c.blink = $urandom_range(0, 3) == 0;
    return c;
  endfunction

  task automatic send_cell(input cell_t c);
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < 36) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, c.blink, c.font, c.row, c.col, c.ink, c.size, c.flags, c.code};
    s_tuser <= c.cs;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    rasterize_cell(c);
  endtask

  task automatic drain_writes();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (index == CFG_RENDER_MODE) render_mode_cfg = data;
    else if (index == CFG_CONCEAL) conceal_cfg = data[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [1:0] mode, input logic [1:0] conceal);
    drain_writes();
    write_reg(CFG_RENDER_MODE, mode);
    write_reg(CFG_CONCEAL, conceal);
  endtask

  task automatic test_directed_cells();
    send_cell(make_cell(7'h00, CS_G0, F_NONE, SZ_NORMAL, 3'd7, 6'd0, 5'd0, FONT_ONES, 1'b0));
    send_cell(make_cell(7'h7F, CS_G0, F_INVERT, SZ_NORMAL, 3'd0, 6'd39, 5'd24, FONT_ZERO, 1'b0));
    send_cell(make_cell(7'h7F, CS_G1, F_NONE, SZ_NORMAL, 3'd7, 6'd10, 5'd5, FONT_ZERO, 1'b0));
    send_cell(make_cell(7'h7F, CS_G1, F_SEPARATED, SZ_NORMAL, 3'd2, 6'd11, 5'd5, FONT_ONES,
                        1'b0));
    send_cell(make_cell(MOSAIC_TOP_BAR, CS_G1, F_UNDERLINE, SZ_NORMAL, 3'd7, 6'd12, 5'd6,
                        FONT_ZERO, 1'b0));
    send_cell(make_cell(7'h00, CS_G1, F_UNDERLINE | F_INVERT, SZ_NORMAL, 3'd3, 6'd13, 5'd6,
                        FONT_ONES, 1'b0));
    send_cell(make_cell(7'h1F, CS_G1, F_NONE, SZ_NORMAL, 3'd7, 6'd14, 5'd7, FONT_ZERO, 1'b0));
    send_cell(make_cell(7'h40, CS_G1, F_SEPARATED, SZ_NORMAL, 3'd7, 6'd15, 5'd7, FONT_ZERO,
                        1'b0));
    send_cell(make_cell(7'h41, CS_G2, F_NONE, SZ_DHEIGHT, 3'd1, 6'd3, 5'd0, FONT_ALT, 1'b0));
    send_cell(make_cell(7'h42, CS_G0, F_UNDERLINE, SZ_DHEIGHT, 3'd4, 6'd4, 5'd24, FONT_MIX,
                        1'b0));
    send_cell(make_cell(7'h43, CS_G0, F_NONE, SZ_DWIDTH, 3'd5, 6'd39, 5'd2, FONT_MIX, 1'b0));
    send_cell(make_cell(7'h44, CS_G0, F_INVERT, SZ_DWIDTH, 3'd6, 6'd38, 5'd2, FONT_ALT, 1'b0));
    send_cell(make_cell(7'h45, CS_G0, F_NONE, SZ_DSIZE, 3'd2, 6'd0, 5'd1, FONT_MIX, 1'b0));
    send_cell(make_cell(7'h46, CS_SPARE, F_NONE, SZ_DSIZE, 3'd0, 6'd39, 5'd0, FONT_ONES,
                        1'b0));
    send_cell(make_cell(7'h2A, CS_G1, F_FLASH | F_INVERT, SZ_DSIZE, 3'd7, 6'd20, 5'd9,
                        FONT_ONES, 1'b1));
    send_cell(make_cell(7'h2A, CS_G0, F_FLASH, SZ_NORMAL, 3'd7, 6'd21, 5'd9, FONT_MIX, 1'b0));
    send_cell(make_cell(7'h55, CS_G0, F_NONE, SZ_NORMAL, 3'd7, 6'd63, 5'd31, FONT_ONES,
                        1'b1));
    send_cell(make_cell(7'h2B, CS_G0, F_CONCEAL, SZ_NORMAL, 3'd7, 6'd22, 5'd9, FONT_MIX,
                        1'b0));
  endtask

  task automatic test_register_settings();
    set_config(RM_DITHER_ALL, 2'd1);
    send_cell(make_cell(7'h30, CS_G0, F_CONCEAL | F_UNDERLINE, SZ_NORMAL, 3'd6, 6'd5, 5'd3,
                        FONT_ONES, 1'b0));
    send_cell(make_cell(7'h31, CS_G2, F_NONE, SZ_DWIDTH, 3'd4, 6'd6, 5'd3, FONT_ONES, 1'b0));
    set_config(RM_RAW, 2'd0);
    send_cell(make_cell(7'h7F, CS_G1, F_CONCEAL, SZ_NORMAL, 3'd0, 6'd7, 5'd4, FONT_ZERO,
                        1'b0));
    send_cell(make_cell(7'h32, CS_G0, F_NONE, SZ_NORMAL, 3'd0, 6'd8, 5'd4, FONT_MIX, 1'b0));
    set_config(RM_SPARE, 2'd3);
    send_cell(make_cell(7'h5F, CS_G1, F_CONCEAL | F_SEPARATED, SZ_DSIZE, 3'd1, 6'd9, 5'd10,
                        FONT_ONES, 1'b0));
    send_cell(make_cell(7'h33, CS_G2, F_NONE, SZ_DHEIGHT, 3'd0, 6'd9, 5'd12, FONT_ALT, 1'b0));
  endtask

  task automatic test_random_cells();
    logic [1:0] mode;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) mode = RM_HYBRID;
      else if (phase == RANDOM_PHASES - 1) mode = RM_SPARE;
      else mode = 2'($urandom_range(0, 3));
      set_config(mode, 2'($urandom_range(0, 3)));
      if (phase == 1) begin
        write_reg(CFG_SPARE_A, 2'($urandom_range(0, 3)));
        write_reg(CFG_SPARE_B, 2'($urandom_range(0, 3)));
      end
      no_idle = phase == 2;
      for (int n = 0; n < PHASE_CELLS; n++) begin
        send_cell(random_cell());
        if (n == PHASE_CELLS / 2) drain_writes();
      end
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected write, got addr %0d byte %h last %b", $time,
                 m_tdata[12:0], m_tdata[20:13], m_tlast);
        err_count++;
      end else begin
        expected_write = pending_writes.pop_front();
        if (m_tdata[12:0] !== expected_write.addr) begin
          $display("%0t: fb_address expected %0d, got %0d", $time, expected_write.addr,
                   m_tdata[12:0]);
          err_count++;
        end
        if (m_tdata[20:13] !== expected_write.pix) begin
          $display("%0t: fb_byte expected %h, got %h", $time, expected_write.pix,
                   m_tdata[20:13]);
          err_count++;
        end
        if (m_tlast !== expected_write.last) begin
          $display("%0t: last_write expected %b, got %b", $time, expected_write.last, m_tlast);
          err_count++;
        end
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("[videotex_cell_rasterizer_top] ERROR");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_cells();
    test_register_settings();
    test_random_cells();
    drain_writes();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_writes.size() == 0) begin
      $display("[videotex_cell_rasterizer_top] OK");
    end else begin
      $display("[videotex_cell_rasterizer_top] ERROR");
    end
    $finish;
  end

endmodule
